FILE: rtl/core/latency_histogram_percentile_core_macros.svh
// Assertion macros for the latency histogram percentile core.
`ifndef LATENCY_HISTOGRAM_PERCENTILE_CORE_MACROS_SVH
`define LATENCY_HISTOGRAM_PERCENTILE_CORE_MACROS_SVH
`ifndef SYNTH
`define LHP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lhp assertion failed");
`define LHP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lhp assertion failed");
`else
`define LHP_ASSERT_IMPL(lbl, ante, cons)
`define LHP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/core/lhp_pkg.sv
// Shared constants and types for the latency histogram percentile core.
`timescale 1ns / 1ps
package lhp_pkg;

  localparam int NUM_BUCKETS = 1024;
  localparam int BKT_W       = $clog2(NUM_BUCKETS);
  localparam int NB_W        = $clog2(NUM_BUCKETS + 1);

  localparam int CNT_W  = 32;
  localparam int VAL_W  = 32;
  localparam int SUM_W  = 64;
  localparam int BW_W   = 21;
  localparam int BIU_W  = 11;
  localparam int PCT_W  = 7;
  localparam int PV_W   = 34;
  localparam int CFG_W  = 32;
  localparam int CFGI_W = 2;

  localparam int PCT_SCALE   = 100;
  localparam int PROD_W      = CNT_W + PCT_W;
  localparam int DIV_W       = (PROD_W > BW_W + BKT_W) ? PROD_W : BW_W + BKT_W;
  localparam int STP_W       = $clog2(DIV_W + 1);
  // walk total, kept multiplied by PCT_SCALE
  localparam int ACC_W       = CNT_W + BKT_W + 1 + PCT_W;
  localparam int MUL_W       = BW_W + NB_W;
  localparam int PVS_W       = ((MUL_W > VAL_W + 1) ? MUL_W : VAL_W + 1) + 1;

  localparam logic [BW_W-1:0]  BW_RESET   = BW_W'(100);
  localparam logic [VAL_W-1:0] RMIN_RESET = '0;
  localparam logic [VAL_W-1:0] RMAX_RESET = VAL_W'(1000000);
  localparam logic [BIU_W-1:0] BIU_RESET  = BIU_W'(1024);

  localparam logic ACT_RECORD = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  typedef enum logic [CFGI_W-1:0] {
    CFG_BUCKET_WIDTH,
    CFG_RANGE_MIN,
    CFG_RANGE_MAX,
    CFG_BUCKETS_IN_USE
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_CLASS,
    ST_DIV,
    ST_BKT_RD,
    ST_BKT_WR,
    ST_WALK,
    ST_WALK_ADD,
    ST_QMUL,
    ST_QOUT
  } lhp_state_t;

  typedef struct packed {
    logic             go;
    logic [STP_W-1:0] steps;
  } div_req_t;

endpackage

FILE: rtl/core/lhp_div.sv
// Restoring divider, one quotient bit per cycle, for the bucket index.
`timescale 1ns / 1ps
module lhp_div
  import lhp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor_top,
  output logic             busy,
  output logic [DIV_W-1:0] quot
);

  logic             run_r, run_nxt;
  logic [STP_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] dsh_r, dsh_nxt;
  logic [DIV_W-1:0] q_r, q_nxt;
  logic             fits;

  assign fits = (rem_r >= dsh_r);

  always_comb begin
    run_nxt = run_r;
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    dsh_nxt = dsh_r;
    q_nxt   = q_r;
    if (req.go) begin
      run_nxt = 1'b1;
      cnt_nxt = req.steps;
      rem_nxt = dividend;
      dsh_nxt = divisor_top;
      q_nxt   = '0;
    end else if (run_r) begin
      if (fits) begin
        rem_nxt = rem_r - dsh_r;
      end
      q_nxt   = {q_r[DIV_W-2:0], fits};
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      run_nxt = (cnt_r != STP_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
  end

  assign busy = run_r;
  assign quot = q_r;

endmodule

FILE: rtl/core/latency_histogram_percentile_core.sv
// Latency histogram percentile core: a fixed-width bucket histogram held in a
// 1024 x 32 bucket RAM. After reset the core runs a clearing pass over all
// 1024 buckets with busy high. An item is taken when start is high and busy low;
// its result shows on the out_ ports for exactly one cycle with out_valid high
// and must be captured then. A record skips the divider when the sample lies
// at or outside the range edges or beyond the full 1024-bucket span; otherwise
// the 10-step serial divider forms the bucket index. The bucket read-modify-write
// follows in both cases. A query walks the buckets with one RAM read and
// accumulate per bucket, with the running total kept scaled by 100 and compared
// against count times percent. Configuration writes take effect at once and are
// meant for idle periods only.
`timescale 1ns / 1ps
`include "latency_histogram_percentile_core_macros.svh"
module latency_histogram_percentile_core
  import lhp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_action,
  input  logic signed [VAL_W-1:0]  in_sample_value,
  input  logic [PCT_W-1:0]         in_percent,
  output logic                     out_valid,
  output logic signed [PV_W-1:0]   out_percentile_value,
  output logic [CNT_W-1:0]         out_count_out,
  output logic signed [VAL_W-1:0]  out_min_out,
  output logic signed [VAL_W-1:0]  out_max_out,
  output logic signed [SUM_W-1:0]  out_sum_out,
  input  logic                     cfg_we,
  input  logic [CFGI_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  lhp_state_t state_r, state_nxt;

  logic [BW_W-1:0]          bw_r;
  logic signed [VAL_W-1:0]  rmin_r;
  logic signed [VAL_W-1:0]  rmax_r;
  logic [BIU_W-1:0]         biu_r;

  logic [CNT_W-1:0]         count_r, count_nxt;
  logic signed [VAL_W-1:0]  min_r, min_nxt;
  logic signed [VAL_W-1:0]  max_r, max_nxt;
  logic [SUM_W-1:0]         sum_r, sum_nxt;
  logic [BKT_W-1:0]         clr_idx_r, clr_idx_nxt;
  logic                     out_valid_r, out_valid_nxt;

  logic                     action_r, action_nxt;
  logic signed [VAL_W-1:0]  sample_r, sample_nxt;
  logic [PCT_W-1:0]         pct_r, pct_nxt;
  logic [VAL_W-1:0]         diff_r, diff_nxt;
  logic                     ge_hi_r, ge_hi_nxt;
  logic                     le_lo_r, le_lo_nxt;
  logic [BKT_W-1:0]         idx_r, idx_nxt;
  logic [PROD_W-1:0]        prod_r, prod_nxt;
  logic [ACC_W-1:0]         acc_r, acc_nxt;
  logic [NB_W-1:0]          i_r, i_nxt;
  logic [MUL_W-1:0]         mul_r, mul_nxt;
  logic [PV_W-1:0]          out_pv_r, out_pv_nxt;
  logic [CNT_W-1:0]         out_count_r, out_count_nxt;
  logic [VAL_W-1:0]         out_min_r, out_min_nxt;
  logic [VAL_W-1:0]         out_max_r, out_max_nxt;
  logic [SUM_W-1:0]         out_sum_r, out_sum_nxt;

  logic [CNT_W-1:0]         bkt_mem [NUM_BUCKETS];
  logic [CNT_W-1:0]         mem_rdata_r;
  logic                     mem_we;
  logic [BKT_W-1:0]         mem_waddr;
  logic [CNT_W-1:0]         mem_wdata;
  logic [BKT_W-1:0]         mem_raddr;

  logic [BW_W-1:0]          bw_eff;
  logic [NB_W-1:0]          n_eff;
  logic [BKT_W-1:0]         top_idx;
  logic [PVS_W-1:0]         pv_sum;

  div_req_t                 div_req;
  logic [DIV_W-1:0]         div_dvd;
  logic [DIV_W-1:0]         div_dsr;
  logic                     div_busy;
  logic [DIV_W-1:0]         div_quot;

  assign bw_eff  = (bw_r == '0) ? BW_W'(1) : bw_r;
  assign n_eff   = (biu_r == '0) ? NB_W'(1) :
                   (32'(biu_r) > 32'(NUM_BUCKETS)) ? NB_W'(NUM_BUCKETS) : NB_W'(biu_r);
  assign top_idx = BKT_W'(n_eff - 1'b1);
  assign pv_sum  = PVS_W'({{(PVS_W-VAL_W){rmin_r[VAL_W-1]}}, rmin_r}) + PVS_W'(mul_r);

  assign busy = (state_r != ST_IDLE);

  lhp_div u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (div_req),
    .dividend    (div_dvd),
    .divisor_top (div_dsr),
    .busy        (div_busy),
    .quot        (div_quot)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    sum_nxt       = sum_r;
    clr_idx_nxt   = clr_idx_r;
    out_valid_nxt = 1'b0;
    action_nxt    = action_r;
    sample_nxt    = sample_r;
    pct_nxt       = pct_r;
    diff_nxt      = diff_r;
    ge_hi_nxt     = ge_hi_r;
    le_lo_nxt     = le_lo_r;
    idx_nxt       = idx_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    i_nxt         = i_r;
    mul_nxt       = mul_r;
    out_pv_nxt    = out_pv_r;
    out_count_nxt = out_count_r;
    out_min_nxt   = out_min_r;
    out_max_nxt   = out_max_r;
    out_sum_nxt   = out_sum_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = '0;
    mem_raddr     = idx_r;
    div_req.go    = 1'b0;
    div_req.steps = '0;
    div_dvd       = '0;
    div_dsr       = '0;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_r;
        if (clr_idx_r == BKT_W'(NUM_BUCKETS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (start) begin
          action_nxt = in_action;
          sample_nxt = in_sample_value;
          pct_nxt    = in_percent;
          state_nxt  = ST_PREP;
        end
      end
      ST_PREP: begin
        if (action_r == ACT_RECORD) begin
          count_nxt = (count_r == '1) ? count_r : count_r + 1'b1;
          if (sample_r < min_r) begin
            min_nxt = sample_r;
          end
          if (sample_r > max_r) begin
            max_nxt = sample_r;
          end
          sum_nxt   = sum_r + {{(SUM_W-VAL_W){sample_r[VAL_W-1]}}, sample_r};
          diff_nxt  = sample_r - rmin_r;
          ge_hi_nxt = (sample_r >= rmax_r);
          le_lo_nxt = (sample_r <= rmin_r);
          state_nxt = ST_CLASS;
        end else begin
          // total below count * percent / 100 iff 100 * (total + 1) <= count * percent
          prod_nxt  = PROD_W'(count_r) * PROD_W'(pct_r);
          acc_nxt   = ACC_W'(PCT_SCALE);
          i_nxt     = '0;
          state_nxt = ST_WALK;
        end
      end
      ST_CLASS: begin
        if (ge_hi_r) begin
          idx_nxt   = top_idx;
          state_nxt = ST_BKT_RD;
        end else if (le_lo_r) begin
          idx_nxt   = '0;
          state_nxt = ST_BKT_RD;
        end else if (DIV_W'(diff_r) >= (DIV_W'(bw_eff) << BKT_W)) begin
          idx_nxt   = top_idx;
          state_nxt = ST_BKT_RD;
        end else begin
          div_req.go    = 1'b1;
          div_req.steps = STP_W'(BKT_W);
          div_dvd       = DIV_W'(diff_r);
          div_dsr       = DIV_W'(bw_eff) << (BKT_W - 1);
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!div_busy) begin
          idx_nxt   = (div_quot >= DIV_W'(n_eff)) ? top_idx : div_quot[BKT_W-1:0];
          state_nxt = ST_BKT_RD;
        end
      end
      ST_BKT_RD: begin
        mem_raddr = idx_r;
        state_nxt = ST_BKT_WR;
      end
      ST_BKT_WR: begin
        mem_we        = 1'b1;
        mem_waddr     = idx_r;
        mem_wdata     = (mem_rdata_r == '1) ? mem_rdata_r : mem_rdata_r + 1'b1;
        out_valid_nxt = 1'b1;
        out_pv_nxt    = '0;
        out_count_nxt = count_r;
        out_min_nxt   = min_r;
        out_max_nxt   = max_r;
        out_sum_nxt   = sum_r;
        state_nxt     = ST_IDLE;
      end
      ST_WALK: begin
        if ((acc_r <= ACC_W'(prod_r)) && (i_r < n_eff)) begin
          mem_raddr = i_r[BKT_W-1:0];
          state_nxt = ST_WALK_ADD;
        end else begin
          state_nxt = ST_QMUL;
        end
      end
      ST_WALK_ADD: begin
        // bucket count times 100 as 64 + 32 + 4
        acc_nxt   = acc_r + (ACC_W'(mem_rdata_r) << 6) + (ACC_W'(mem_rdata_r) << 5)
                    + (ACC_W'(mem_rdata_r) << 2);
        i_nxt     = i_r + 1'b1;
        state_nxt = ST_WALK;
      end
      ST_QMUL: begin
        mul_nxt   = MUL_W'(bw_eff) * MUL_W'(i_r);
        state_nxt = ST_QOUT;
      end
      ST_QOUT: begin
        out_valid_nxt = 1'b1;
        out_pv_nxt    = pv_sum[PV_W-1:0];
        out_count_nxt = count_r;
        out_min_nxt   = min_r;
        out_max_nxt   = max_r;
        out_sum_nxt   = sum_r;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      min_r       <= {1'b0, {(VAL_W-1){1'b1}}};
      max_r       <= {1'b1, {(VAL_W-1){1'b0}}};
      sum_r       <= '0;
      bw_r        <= BW_RESET;
      rmin_r      <= RMIN_RESET;
      rmax_r      <= RMAX_RESET;
      biu_r       <= BIU_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      sum_r       <= sum_nxt;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_BUCKET_WIDTH:   bw_r   <= cfg_data[BW_W-1:0];
          CFG_RANGE_MIN:      rmin_r <= cfg_data[VAL_W-1:0];
          CFG_RANGE_MAX:      rmax_r <= cfg_data[VAL_W-1:0];
          CFG_BUCKETS_IN_USE: biu_r  <= cfg_data[BIU_W-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    action_r    <= action_nxt;
    sample_r    <= sample_nxt;
    pct_r       <= pct_nxt;
    diff_r      <= diff_nxt;
    ge_hi_r     <= ge_hi_nxt;
    le_lo_r     <= le_lo_nxt;
    idx_r       <= idx_nxt;
    prod_r      <= prod_nxt;
    acc_r       <= acc_nxt;
    i_r         <= i_nxt;
    mul_r       <= mul_nxt;
    out_pv_r    <= out_pv_nxt;
    out_count_r <= out_count_nxt;
    out_min_r   <= out_min_nxt;
    out_max_r   <= out_max_nxt;
    out_sum_r   <= out_sum_nxt;
  end

  // bucket RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bkt_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= bkt_mem[mem_raddr];
  end

  assign out_valid            = out_valid_r;
  assign out_percentile_value = out_pv_r;
  assign out_count_out        = out_count_r;
  assign out_min_out          = out_min_r;
  assign out_max_out          = out_max_r;
  assign out_sum_out          = out_sum_r;

  `LHP_ASSERT_IMPL(a_strobe_when_idle, out_valid_r, state_r == ST_IDLE)
  `LHP_ASSERT_IMPL(a_bucket_in_use, state_r == ST_BKT_RD, NB_W'(idx_r) < n_eff)
  `LHP_ASSERT_IMPL(a_walk_in_use, state_r == ST_WALK_ADD, i_r < n_eff)
  `LHP_ASSERT_NEXT(a_div_on_entry, div_req.go, div_busy)

endmodule

FILE: tb/sv/latency_histogram_percentile_core_tb.sv
// Testbench for the latency histogram percentile core: directed and random transfers.
`timescale 1ns / 1ps
module latency_histogram_percentile_core_tb;
  import lhp_pkg::*;

  localparam longint CYCLE_LIMIT = 4_000_000;
  localparam int RANDOM_ITEMS_PER_SETTING = 225;

  typedef struct packed {
    logic [PV_W-1:0]  pv;
    logic [CNT_W-1:0] count;
    logic [VAL_W-1:0] smallest;
    logic [VAL_W-1:0] largest;
    logic [SUM_W-1:0] sum;
  } hist_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic in_action;
  logic signed [VAL_W-1:0] in_sample_value;
  logic [PCT_W-1:0] in_percent;
  logic out_valid;
  logic signed [PV_W-1:0] out_percentile_value;
  logic [CNT_W-1:0] out_count_out;
  logic signed [VAL_W-1:0] out_min_out;
  logic signed [VAL_W-1:0] out_max_out;
  logic signed [SUM_W-1:0] out_sum_out;
  logic cfg_we;
  logic [CFGI_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  // histogram shadow state
  logic [BW_W-1:0] hist_width;
  logic signed [VAL_W-1:0] hist_lo_edge;
  logic signed [VAL_W-1:0] hist_hi_edge;
  logic [BIU_W-1:0] hist_nbuckets;
  logic [CNT_W-1:0] hist_bins [NUM_BUCKETS];
  logic [CNT_W-1:0] hist_count;
  logic signed [VAL_W-1:0] hist_smallest;
  logic signed [VAL_W-1:0] hist_largest;
  logic [SUM_W-1:0] hist_sum;

  hist_result_t pending_results[$];
  int err_count = 0;
  int sender_gap_pct = 0;
  longint cycle_count = 0;

  latency_histogram_percentile_core DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_action            (in_action),
    .in_sample_value      (in_sample_value),
    .in_percent           (in_percent),
    .out_valid            (out_valid),
    .out_percentile_value (out_percentile_value),
    .out_count_out        (out_count_out),
    .out_min_out          (out_min_out),
    .out_max_out          (out_max_out),
    .out_sum_out          (out_sum_out),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint width_in_effect();
    return (hist_width == '0) ? 64'sd1 : longint'({43'b0, hist_width});
  endfunction

  function automatic int buckets_in_effect();
    if (hist_nbuckets == '0) return 1;
    if (hist_nbuckets > NUM_BUCKETS) return NUM_BUCKETS;
    return int'(hist_nbuckets);
  endfunction

  function automatic logic signed [VAL_W-1:0] clamp_to_sample(longint x);
    if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[VAL_W-1:0];
  endfunction

  function automatic void clear_histogram();
    hist_width = BW_RESET;
    hist_lo_edge = RMIN_RESET;
    hist_hi_edge = RMAX_RESET;
    hist_nbuckets = BIU_RESET;
    foreach (hist_bins[i]) hist_bins[i] = '0;
    hist_count = '0;
    hist_smallest = 32'sh7FFFFFFF;
    hist_largest = 32'sh80000000;
    hist_sum = '0;
  endfunction

  function automatic void record_sample(logic signed [VAL_W-1:0] sample);
    longint v;
    longint lo;
    longint hi;
    longint q;
    int n;
    int idx;
    v = sample;
    lo = hist_lo_edge;
    hi = hist_hi_edge;
    n = buckets_in_effect();
    if (hist_count != 32'hFFFFFFFF) hist_count = hist_count + 1'b1;
    if (sample < hist_smallest) hist_smallest = sample;
    if (sample > hist_largest) hist_largest = sample;
    hist_sum = hist_sum + 64'(v);
    if (v >= hi) begin
      idx = n - 1;
    end else if (v <= lo) begin
      idx = 0;
    end else begin
      q = (v - lo) / width_in_effect();
      idx = (q >= n) ? n - 1 : int'(q);
    end
    if (hist_bins[idx] != 32'hFFFFFFFF) hist_bins[idx] = hist_bins[idx] + 1'b1;
  endfunction

  function automatic logic [PV_W-1:0] percentile_of(logic [PCT_W-1:0] pct);
    logic [63:0] target;
    logic [63:0] running;
    longint answer;
    int n;
    int i;
    target = (64'(hist_count) * 64'(pct)) / 64'(PCT_SCALE);
    running = '0;
    n = buckets_in_effect();
    i = 0;
    while (running < target && i < n) begin
      running = running + 64'(hist_bins[i]);
      i++;
    end
    answer = longint'(hist_lo_edge) + width_in_effect() * longint'(i);
    return answer[PV_W-1:0];
  endfunction

  function automatic void predict_transfer(logic act, logic signed [VAL_W-1:0] sample,
                                           logic [PCT_W-1:0] pct);
    hist_result_t r;
    r.pv = '0;
    if (act == ACT_RECORD) record_sample(sample);
    else r.pv = percentile_of(pct);
    r.count = hist_count;
    r.smallest = hist_smallest;
    r.largest = hist_largest;
    r.sum = hist_sum;
    pending_results.push_back(r);
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    hist_result_t exp_r;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no expectation pending");
        err_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("percentile_value", {30'b0, exp_r.pv}, {30'b0, out_percentile_value});
        check_field("count_out", {32'b0, exp_r.count}, {32'b0, out_count_out});
        check_field("min_out", {32'b0, exp_r.smallest}, {32'b0, out_min_out});
        check_field("max_out", {32'b0, exp_r.largest}, {32'b0, out_max_out});
        check_field("sum_out", exp_r.sum, out_sum_out);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // start stays high across back-to-back transfers; it drops only in a gap or while waiting to settle
  task automatic submit_item(logic act, logic signed [VAL_W-1:0] sample,
                             logic [PCT_W-1:0] pct);
    while ($urandom_range(99) < sender_gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_action <= act;
    in_sample_value <= sample;
    in_percent <= pct;
    do @(posedge clk); while (busy !== 1'b0);
    predict_transfer(act, sample, pct);
  endtask

  task automatic wait_until_settled();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_BUCKET_WIDTH:   hist_width = val[BW_W-1:0];
      CFG_RANGE_MIN:      hist_lo_edge = val;
      CFG_RANGE_MAX:      hist_hi_edge = val;
      CFG_BUCKETS_IN_USE: hist_nbuckets = val[BIU_W-1:0];
      default: ;
    endcase
  endtask

  // upper bits beyond each register's width are filled with noise
  task automatic apply_settings(logic [BW_W-1:0] bw, logic signed [VAL_W-1:0] lo,
                                logic signed [VAL_W-1:0] hi, logic [BIU_W-1:0] nb);
    logic [CFG_W-1:0] noise;
    wait_until_settled();
    noise = $urandom;
    write_reg(CFG_BUCKET_WIDTH, {noise[CFG_W-1:BW_W], bw});
    write_reg(CFG_RANGE_MIN, lo);
    write_reg(CFG_RANGE_MAX, hi);
    write_reg(CFG_BUCKETS_IN_USE, {noise[CFG_W-1:BIU_W], nb});
    cfg_we <= 1'b0;
  endtask

  task automatic record(logic signed [VAL_W-1:0] sample);
    submit_item(ACT_RECORD, sample, PCT_W'($urandom));
  endtask

  task automatic ask(logic [PCT_W-1:0] pct);
    submit_item(ACT_QUERY, $urandom, pct);
  endtask

  task automatic test_empty_histogram();
    ask(7'd50);
    ask(7'd0);
  endtask

  task automatic test_range_edges();
    record(32'sd0);
    record(32'sd1000000);
    record(32'sd999999);
    record(32'sh80000000);
    record(32'sh7FFFFFFF);
    record(32'sd150);
    record(32'sd99);
    ask(7'd0);
    ask(7'd100);
    ask(7'd127);
    ask(7'd50);
  endtask

  task automatic test_zero_width_and_bucket_clamp();
    apply_settings('0, -32'sd10, 32'sd10, '0);
    record(-32'sd10);
    record(32'sd5);
    record(32'sd10);
    ask(7'd100);
    apply_settings({BW_W{1'b1}}, -32'sd10, 32'sd10, {BIU_W{1'b1}});
    record(32'sd3);
    ask(7'd100);
  endtask

  task automatic test_inverted_range();
    apply_settings(21'd3, 32'sd100, -32'sd100, 11'd5);
    record(-32'sd100);
    record(32'sd50);
    record(-32'sd200);
    ask(7'd60);
  endtask

  task automatic random_item();
    longint w;
    longint span;
    longint unsigned pick;
    int sel;
    if ($urandom_range(99) < 12) begin
      ask(($urandom_range(9) < 7) ? PCT_W'($urandom_range(100)) : PCT_W'($urandom));
    end else begin
      sel = $urandom_range(99);
      w = width_in_effect();
      if (sel < 15) begin
        case ($urandom_range(4))
          0: record(hist_lo_edge);
          1: record(hist_hi_edge);
          2: record(hist_lo_edge + 1'b1);
          3: record(hist_hi_edge - 1'b1);
          default: record(hist_lo_edge - 1'b1);
        endcase
      end else if (sel < 30) begin
        record($urandom);
      end else begin
        span = w * buckets_in_effect() + 2 * w;
        pick = {$urandom, $urandom};
        record(clamp_to_sample(longint'(hist_lo_edge) - w + longint'(pick % span)));
      end
    end
    if ($urandom_range(99) == 0) wait_until_settled();
  endtask

  task automatic test_random_traffic();
    logic [BW_W-1:0] bw;
    logic signed [VAL_W-1:0] lo;
    logic [BIU_W-1:0] nb;
    for (int s = 0; s < 6; s++) begin
      sender_gap_pct = (s < 2) ? 32 : (s < 4) ? 49 : 0;
      case (s)
        0: apply_settings(BW_RESET, RMIN_RESET, RMAX_RESET, BIU_RESET);
        1: apply_settings(21'd1, -32'sd50, 32'sd20, 11'd70);
        2: apply_settings('0, 32'sh80000000, 32'sh7FFFFFFF, '0);
        3: apply_settings({BW_W{1'b1}}, 32'sh80000000, 32'sh7FFFFFFF, {BIU_W{1'b1}});
        4: apply_settings(21'd7, 32'sd500, -32'sd500, 11'd13);
        default: begin
          bw = BW_W'($urandom_range(4096, 1));
          lo = $urandom;
          nb = BIU_W'($urandom_range(NUM_BUCKETS, 1));
          apply_settings(bw, lo,
                         clamp_to_sample(longint'(lo) + longint'(bw) * longint'(nb)), nb);
        end
      endcase
      repeat (RANDOM_ITEMS_PER_SETTING) random_item();
    end
  endtask

  initial begin
    clear_histogram();
    rst_n <= 1'b0;
    start <= 1'b0;
    in_action <= ACT_RECORD;
    in_sample_value <= '0;
    in_percent <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_BUCKET_WIDTH;
    cfg_data <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_histogram();
    test_range_edges();
    test_zero_width_and_bucket_clamp();
    test_inverted_range();
    test_random_traffic();

    wait_until_settled();
    repeat (50) @(posedge clk);
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: latency_histogram_percentile_core.f
+incdir+rtl/core
rtl/core/lhp_pkg.sv
rtl/core/lhp_div.sv
rtl/core/latency_histogram_percentile_core.sv
tb/sv/latency_histogram_percentile_core_tb.sv
